FILE: rtl/core/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg: shared types and codes for the sorted list engine
// Request codes, the request transaction and the result transaction as they
// travel between the core and its engine.
// ----------------------------------------------------------------------------
package sle_pkg;

  // Fixed field widths of the request and result transactions
  localparam int unsigned REQ_W       = 3;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned CNT_FIELD_W = 9;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_LFIND  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_BFIND  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

  // Request transaction
  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic signed [KEY_W-1:0] key;
    logic [POS_W-1:0]        index;
  } cmd_t;

  // Result transaction
  typedef struct packed {
    logic                    ok;
    logic [POS_W-1:0]        position;
    logic signed [KEY_W-1:0] value;
    logic [CNT_FIELD_W-1:0]  count;
  } res_t;

endpackage

FILE: rtl/core/sorted_list_engine_core.sv
// ----------------------------------------------------------------------------
// sorted_list_engine_core: sorted key list with insert, remove and search
// Top level: request intake, engine and the result output register.
// ----------------------------------------------------------------------------
// One request transaction is worked on at a time, and each gives one result
// transaction. Insert moves every entry not below the key up by one, from
// the top down, then writes the key (an empty store is written directly);
// remove scans to the hit and shifts the entries above it down; linear find
// scans to the hit or to the end; binary find reads, then compares, at each
// midpoint probe; read fetches one entry; a rejected request goes straight
// to its result. The cost is set by the single write and single read port
// of the key memory, which moves or compares one entry per cycle. The next
// request is taken as soon as the previous result has moved into the output
// register, even while that result still waits on out_stall. Positions
// report the low 8 bits, count the low 9 bits.
module sorted_list_engine_core #(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [sle_pkg::REQ_W-1:0]            in_req_type,
  input  logic signed [sle_pkg::KEY_W-1:0]     in_key,
  input  logic [sle_pkg::POS_W-1:0]            in_index,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_ok,
  output logic [sle_pkg::POS_W-1:0]            out_position,
  output logic signed [sle_pkg::KEY_W-1:0]     out_value,
  output logic [sle_pkg::CNT_FIELD_W-1:0]      out_count
);
  import sle_pkg::*;

  cmd_t cmd;
  logic cmd_ready;
  logic res_valid;
  res_t res;
  logic res_take;
  logic out_valid_r;
  res_t out_r;

  // Request transaction into the engine
  assign cmd.req_type = in_req_type;
  assign cmd.key      = in_key;
  assign cmd.index    = in_index;
  assign in_stall     = !cmd_ready;

  sle_engine #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // Output register: loads when empty or draining this cycle
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ok       = out_r.ok;
  assign out_position = out_r.position;
  assign out_value    = out_r.value;
  assign out_count    = out_r.count;

endmodule

FILE: rtl/core/sle_engine.sv
// ----------------------------------------------------------------------------
// sle_engine: sorted store and request sequencer
// Holds the keys in one simple dual-port memory (one write, one registered
// read per cycle) and walks it with a sequencer: shift up for insert, scan
// and shift down for remove, scan for linear find, midpoint probes for
// binary find, one read for read-at-index.
// ----------------------------------------------------------------------------
module sle_engine #(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  sle_pkg::cmd_t cmd,
  output logic          cmd_ready,
  output logic          res_valid,
  output sle_pkg::res_t res,
  input  logic          res_take
);
  import sle_pkg::*;

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_INS_ZERO,
    S_SCAN,
    S_SHIFT_DN,
    S_BS_ISSUE,
    S_BS_CMP,
    S_RD,
    S_DONE
  } state_t;

  // Key store
  logic [KEY_BITS-1:0]        mem [CAPACITY];
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [KEY_BITS-1:0]        wr_data;
  logic [AW-1:0]              rd_addr;
  logic signed [KEY_BITS-1:0] rd_data_r;

  // Sequencer state
  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [AW-1:0]              ptr_r, ptr_nxt;
  logic [AW-1:0]              hit_r, hit_nxt;
  logic [CNT_W-1:0]           lo_r, lo_nxt;
  logic [CNT_W-1:0]           hi1_r, hi1_nxt;
  logic signed [KEY_BITS-1:0] key_r, key_nxt;
  logic [REQ_W-1:0]           req_r, req_nxt;
  res_t                       res_r, res_nxt;

  logic signed [KEY_W-1:0]    cmd_key;
  logic signed [KEY_BITS-1:0] cmd_key_k;
  logic [CNT_W:0]             mid_sum;
  logic [AW-1:0]              mid;
  logic                       scan_last;
  logic                       shift_last;

  // Result builder: failed requests report only the count
  function automatic res_t make_res(input logic                       ok,
                                    input logic [AW-1:0]              pos,
                                    input logic signed [KEY_BITS-1:0] val,
                                    input logic [CNT_W-1:0]           cnt);
    res_t r;
    r.ok       = ok;
    r.position = ok ? POS_W'(pos) : '0;
    r.value    = ok ? KEY_W'(val) : '0;
    r.count    = CNT_FIELD_W'(cnt);
    return r;
  endfunction

  // Key narrowed or sign-extended to the store width
  assign cmd_key   = cmd.key;
  assign cmd_key_k = KEY_BITS'(cmd_key);

  // Midpoint of the half-open window [lo, hi1)
  assign mid_sum    = {1'b0, lo_r} + {1'b0, hi1_r} - (CNT_W + 1)'(1);
  assign mid        = AW'(mid_sum >> 1);
  assign scan_last  = (CNT_W'(ptr_r) + CNT_W'(1)) == count_r;
  assign shift_last = (CNT_W'(ptr_r) + CNT_W'(2)) == count_r;

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    hit_nxt   = hit_r;
    lo_nxt    = lo_r;
    hi1_nxt   = hi1_r;
    key_nxt   = key_r;
    req_nxt   = req_r;
    res_nxt   = res_r;
    wr_en     = 1'b0;
    wr_addr   = ptr_r;
    wr_data   = rd_data_r;
    rd_addr   = ptr_r;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          key_nxt = cmd_key_k;
          req_nxt = cmd.req_type;
          case (cmd.req_type)
            REQ_INSERT: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                res_nxt   = make_res(1'b0, '0, '0, count_r);
                state_nxt = S_DONE;
              end else if (count_r == '0) begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = cmd_key_k;
                count_nxt = CNT_W'(1);
                res_nxt   = make_res(1'b1, '0, cmd_key_k, count_nxt);
                state_nxt = S_DONE;
              end else begin
                rd_addr   = AW'(count_r - CNT_W'(1));
                ptr_nxt   = AW'(count_r);
                state_nxt = S_INS;
              end
            end
            REQ_REMOVE, REQ_LFIND: begin
              if (count_r == '0) begin
                res_nxt   = make_res(1'b0, '0, '0, count_r);
                state_nxt = S_DONE;
              end else begin
                rd_addr   = '0;
                ptr_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            REQ_BFIND: begin
              if (count_r == '0) begin
                res_nxt   = make_res(1'b0, '0, '0, count_r);
                state_nxt = S_DONE;
              end else begin
                lo_nxt    = '0;
                hi1_nxt   = count_r;
                state_nxt = S_BS_ISSUE;
              end
            end
            REQ_READ: begin
              if (CMP_W'(cmd.index) < CMP_W'(count_r)) begin
                rd_addr   = AW'(cmd.index);
                ptr_nxt   = AW'(cmd.index);
                state_nxt = S_RD;
              end else begin
                res_nxt   = make_res(1'b0, '0, '0, count_r);
                state_nxt = S_DONE;
              end
            end
            default: begin
              res_nxt   = make_res(1'b0, '0, '0, count_r);
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // rd_data holds entry ptr-1; move it up or drop the key in at ptr
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        rd_addr = ptr_r - AW'(2);
        if (rd_data_r >= key_r) begin
          wr_data = rd_data_r;
          if (ptr_r == AW'(1)) begin
            state_nxt = S_INS_ZERO;
          end else begin
            ptr_nxt = ptr_r - AW'(1);
          end
        end else begin
          wr_data   = key_r;
          count_nxt = count_r + CNT_W'(1);
          res_nxt   = make_res(1'b1, ptr_r, key_r, count_nxt);
          state_nxt = S_DONE;
        end
      end

      // Every entry was larger or equal: key goes to the front
      S_INS_ZERO: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = key_r;
        count_nxt = count_r + CNT_W'(1);
        res_nxt   = make_res(1'b1, '0, key_r, count_nxt);
        state_nxt = S_DONE;
      end

      // rd_data holds entry ptr; the read of ptr+1 is already on its way
      S_SCAN: begin
        rd_addr = ptr_r + AW'(1);
        if (rd_data_r == key_r) begin
          if (req_r == REQ_LFIND) begin
            res_nxt   = make_res(1'b1, ptr_r, key_r, count_r);
            state_nxt = S_DONE;
          end else if (scan_last) begin
            count_nxt = count_r - CNT_W'(1);
            res_nxt   = make_res(1'b1, ptr_r, key_r, count_nxt);
            state_nxt = S_DONE;
          end else begin
            hit_nxt   = ptr_r;
            state_nxt = S_SHIFT_DN;
          end
        end else if (scan_last) begin
          res_nxt   = make_res(1'b0, '0, '0, count_r);
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      // rd_data holds entry ptr+1; move it down to ptr
      S_SHIFT_DN: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wr_data = rd_data_r;
        rd_addr = ptr_r + AW'(2);
        if (shift_last) begin
          count_nxt = count_r - CNT_W'(1);
          res_nxt   = make_res(1'b1, hit_r, key_r, count_nxt);
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      // Probe the midpoint
      S_BS_ISSUE: begin
        rd_addr   = mid;
        ptr_nxt   = mid;
        state_nxt = S_BS_CMP;
      end

      // Narrow the window around the probe
      S_BS_CMP: begin
        if (rd_data_r == key_r) begin
          res_nxt   = make_res(1'b1, ptr_r, key_r, count_r);
          state_nxt = S_DONE;
        end else begin
          if (key_r < rd_data_r) begin
            hi1_nxt = CNT_W'(ptr_r);
          end else begin
            lo_nxt = CNT_W'(ptr_r) + CNT_W'(1);
          end
          if (lo_nxt < hi1_nxt) begin
            state_nxt = S_BS_ISSUE;
          end else begin
            res_nxt   = make_res(1'b0, '0, '0, count_r);
            state_nxt = S_DONE;
          end
        end
      end

      S_RD: begin
        res_nxt   = make_res(1'b1, ptr_r, rd_data_r, count_r);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer registers and result holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    ptr_r <= ptr_nxt;
    hit_r <= hit_nxt;
    lo_r  <= lo_nxt;
    hi1_r <= hi1_nxt;
    key_r <= key_nxt;
    req_r <= req_nxt;
    res_r <= res_nxt;
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign cmd_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_ins_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |-> (ptr_r != '0) && (CNT_W'(ptr_r) <= count_r))
    else $error("insert shift pointer out of range");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_ZERO) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert at front did not grow the count");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_DN) |-> ((CNT_W'(ptr_r) + CNT_W'(2)) <= count_r))
    else $error("remove shift runs past the last entry");

  a_bs_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BS_ISSUE) |-> (lo_r < hi1_r) && (hi1_r <= count_r))
    else $error("binary search window empty or too wide");

endmodule
